FILE: rtl/lfa_pkg.sv
// lfa_pkg: constants, frame role codes and the pipeline stage type of the line
// frame averager. No dependencies; every other file uses it by scoped names.

package lfa_pkg;

   localparam int LINE_PIXELS = 4096;
   localparam int ADDR_W = $clog2(LINE_PIXELS);

   localparam int KIND_W = 2;
   localparam int IDX_W = 12;
   localparam int SMP_W = 12;
   localparam int SUM_W = 20;
   localparam int FRM_W = 8;

   localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIRST = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MIDDLE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_LAST = 2'd3;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [SMP_W-1:0] PIX_MAX = {SMP_W{1'b1}};
   localparam logic [FRM_W-1:0] FRAMES_RESET = 8'd1;

   // restoring divider: quotient bits resolved per stage
   localparam int DIV_STEPS = 4;
   localparam int STEP_BITS = SUM_W / DIV_STEPS;

   typedef struct packed {
      logic valid;
      logic single;
      logic [IDX_W-1:0] index;
      logic eol;
      logic [SMP_W-1:0] sample;
      logic [FRM_W-1:0] rem;
      logic [SUM_W-1:0] qd;
   } pipe_type;

endpackage

FILE: rtl/lfa_req_if.sv
// lfa_req_if: input channel of the line frame averager, one pixel item.
// Depends on lfa_pkg for field widths.

interface lfa_req_if;
   logic valid;
   logic ready;
   logic [lfa_pkg::KIND_W-1:0] kind;
   logic [lfa_pkg::IDX_W-1:0] pixel_index;
   logic [lfa_pkg::SMP_W-1:0] sample;

   modport source (output valid, kind, pixel_index, sample, input ready);
   modport sink (input valid, kind, pixel_index, sample, output ready);
endinterface

FILE: rtl/lfa_rsp_if.sv
// lfa_rsp_if: result channel of the line frame averager, one output pixel item.
// Depends on lfa_pkg for field widths.

interface lfa_rsp_if;
   logic valid;
   logic ready;
   logic [lfa_pkg::SMP_W-1:0] pixel_out;
   logic [lfa_pkg::IDX_W-1:0] index_out;
   logic end_of_line;

   modport source (output valid, pixel_out, index_out, end_of_line, input ready);
   modport sink (input valid, pixel_out, index_out, end_of_line, output ready);
endinterface

FILE: rtl/lfa_accum.sv
// lfa_accum: per-pixel accumulator memory with read-modify-write and write
// forwarding; launches the divider pipeline. Depends on lfa_pkg.

module lfa_accum (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_valid,
   input  logic [lfa_pkg::KIND_W-1:0] in_kind,
   input  logic [lfa_pkg::IDX_W-1:0] in_index,
   input  logic [lfa_pkg::SMP_W-1:0] in_sample,
   output lfa_pkg::pipe_type out_stage
);

   logic [lfa_pkg::SUM_W-1:0] sums [lfa_pkg::LINE_PIXELS];

   logic s1_valid_ff;
   logic [lfa_pkg::KIND_W-1:0] s1_kind_ff;
   logic [lfa_pkg::IDX_W-1:0] s1_index_ff;
   logic [lfa_pkg::SMP_W-1:0] s1_sample_ff;
   logic [lfa_pkg::SUM_W-1:0] rd_data_ff;

   logic wr_valid_ff;
   logic [lfa_pkg::IDX_W-1:0] wr_index_ff;
   logic [lfa_pkg::SUM_W-1:0] wr_sum_ff;

   lfa_pkg::pipe_type stage_ff;
   lfa_pkg::pipe_type stage_in;

   logic in_range;
   logic wr_en;
   logic [lfa_pkg::SUM_W-1:0] base;
   logic [lfa_pkg::SUM_W:0] total;
   logic [lfa_pkg::SUM_W-1:0] new_sum;

   assign in_range = 32'(s1_index_ff) < lfa_pkg::LINE_PIXELS;
   assign wr_en = s1_valid_ff && in_range && (s1_kind_ff != lfa_pkg::KIND_SINGLE);

   // the item one step ahead wrote at the edge this one was read
   assign base = (wr_valid_ff && (wr_index_ff == s1_index_ff)) ? wr_sum_ff : rd_data_ff;
   assign total = {1'b0, base} + (lfa_pkg::SUM_W + 1)'(s1_sample_ff);

   always_comb begin
      case (s1_kind_ff)
         lfa_pkg::KIND_FIRST: new_sum = lfa_pkg::SUM_W'(s1_sample_ff);
         lfa_pkg::KIND_SINGLE: new_sum = '0;
         default: new_sum = total[lfa_pkg::SUM_W] ? lfa_pkg::SUM_MAX
                                                  : total[lfa_pkg::SUM_W-1:0];
      endcase
   end

   always_comb begin
      stage_in.valid = s1_valid_ff && ((s1_kind_ff == lfa_pkg::KIND_SINGLE) ||
                       ((s1_kind_ff == lfa_pkg::KIND_LAST) && in_range));
      stage_in.single = (s1_kind_ff == lfa_pkg::KIND_SINGLE);
      stage_in.index = s1_index_ff;
      stage_in.eol = (32'(s1_index_ff) == (lfa_pkg::LINE_PIXELS - 1));
      stage_in.sample = s1_sample_ff;
      stage_in.rem = '0;
      stage_in.qd = new_sum;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_data_ff <= sums[lfa_pkg::ADDR_W'(in_index)];
         if (wr_en) begin
            sums[lfa_pkg::ADDR_W'(s1_index_ff)] <= new_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
         stage_ff <= '0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         wr_valid_ff <= wr_en;
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff <= in_kind;
         s1_index_ff <= in_index;
         s1_sample_ff <= in_sample;
         wr_index_ff <= s1_index_ff;
         wr_sum_ff <= new_sum;
      end
   end

   assign out_stage = stage_ff;

   a_first_overwrites: assert property (@(posedge clock) disable iff (reset)
      (adv && s1_valid_ff && in_range && (s1_kind_ff == lfa_pkg::KIND_FIRST))
      |=> (wr_valid_ff && (wr_sum_ff == lfa_pkg::SUM_W'($past(s1_sample_ff)))))
      else $error("first frame did not overwrite the accumulator");

   a_out_of_line_no_write: assert property (@(posedge clock) disable iff (reset)
      (adv && s1_valid_ff && !in_range) |=> !wr_valid_ff)
      else $error("pixel beyond the line touched the accumulator");

endmodule

FILE: rtl/lfa_div_step.sv
// lfa_div_step: one registered stage of the restoring divider, resolving
// STEP_BITS quotient bits of the pixel sum. Depends on lfa_pkg.

module lfa_div_step (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic [lfa_pkg::FRM_W-1:0] divisor,
   input  lfa_pkg::pipe_type in_stage,
   output lfa_pkg::pipe_type out_stage
);

   lfa_pkg::pipe_type stage_ff;
   lfa_pkg::pipe_type stage_in;

   always_comb begin
      logic [lfa_pkg::FRM_W:0] part;
      logic [lfa_pkg::FRM_W-1:0] rem;
      logic [lfa_pkg::SUM_W-1:0] qd;
      stage_in = in_stage;
      rem = in_stage.rem;
      qd = in_stage.qd;
      // dividend bits shift out the top, quotient bits in at the bottom
      for (int i = 0; i < lfa_pkg::STEP_BITS; i++) begin
         part = {rem, qd[lfa_pkg::SUM_W-1]};
         qd = {qd[lfa_pkg::SUM_W-2:0], 1'b0};
         if (part >= {1'b0, divisor}) begin
            part = part - {1'b0, divisor};
            qd[0] = 1'b1;
         end
         rem = part[lfa_pkg::FRM_W-1:0];
      end
      stage_in.rem = rem;
      stage_in.qd = qd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign out_stage = stage_ff;

endmodule

FILE: rtl/lfa_out_buf.sv
// lfa_out_buf: final saturation, output register and skid slot that drive the
// result channel and set the pipeline advance. Depends on lfa_pkg, lfa_rsp_if.

module lfa_out_buf (
   input  logic clock,
   input  logic reset,
   input  lfa_pkg::pipe_type in_stage,
   output logic adv,
   lfa_rsp_if.source rsp_ch
);

   logic out_valid_ff;
   logic [lfa_pkg::SMP_W-1:0] out_pixel_ff;
   logic [lfa_pkg::IDX_W-1:0] out_index_ff;
   logic out_eol_ff;

   logic skid_valid_ff;
   logic [lfa_pkg::SMP_W-1:0] skid_pixel_ff;
   logic [lfa_pkg::IDX_W-1:0] skid_index_ff;
   logic skid_eol_ff;

   logic take;
   logic drain;
   logic [lfa_pkg::SMP_W-1:0] pixel;

   assign adv = !skid_valid_ff;
   assign take = adv && in_stage.valid;
   assign drain = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      if (in_stage.single) begin
         pixel = in_stage.sample;
      end else if (in_stage.qd[lfa_pkg::SUM_W-1:lfa_pkg::SMP_W] != '0) begin
         pixel = lfa_pkg::PIX_MAX;
      end else begin
         pixel = in_stage.qd[lfa_pkg::SMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (drain) begin
         out_valid_ff <= skid_valid_ff || take;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (drain) begin
         if (skid_valid_ff) begin
            out_pixel_ff <= skid_pixel_ff;
            out_index_ff <= skid_index_ff;
            out_eol_ff <= skid_eol_ff;
         end else if (take) begin
            out_pixel_ff <= pixel;
            out_index_ff <= in_stage.index;
            out_eol_ff <= in_stage.eol;
         end
      end else if (take) begin
         skid_pixel_ff <= pixel;
         skid_index_ff <= in_stage.index;
         skid_eol_ff <= in_stage.eol;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.pixel_out = out_pixel_ff;
   assign rsp_ch.index_out = out_index_ff;
   assign rsp_ch.end_of_line = out_eol_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot holds an item while the output is empty");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready && take) |=> skid_valid_ff)
      else $error("item lost while the output stalled");

endmodule

FILE: rtl/line_frame_averager_core.sv
// line_frame_averager_core: top level of the line frame averager.
// Depends on lfa_pkg, lfa_req_if, lfa_rsp_if, lfa_accum, lfa_div_step, lfa_out_buf.
//
// Usage:
//   req_ch carries one pixel item per handshake: frame role, pixel index and
//   12-bit sample. rsp_ch returns one result per single or last-frame item:
//   the passed-through sample or the truncated average over frames_to_average
//   frames, its index and an end-of-line flag. First and middle frames only
//   update the per-pixel sum and return nothing.
//   csr_write_enable / csr_write_data write frames_to_average; write it only
//   while no item is in flight.
//   Throughput is one item per cycle while the output does not stall. From
//   acceptance to rsp_ch.valid an item passes an accumulator read stage, a sum
//   stage, four divider stages of five quotient bits each and the output register.
//   Reset clears all valid bits and sets frames_to_average to 1. The sum
//   memory is not cleared; each pixel needs a first frame before it is added to.
//   When the receiver stalls, the pipeline keeps running until one more result
//   sits in the skid slot; req_ch.ready then drops, a registered signal, and
//   every stage holds until the output drains.

module line_frame_averager_core (
   input  logic clock,
   input  logic reset,
   lfa_req_if.sink req_ch,
   lfa_rsp_if.source rsp_ch,
   input  logic csr_write_enable,
   input  logic [lfa_pkg::FRM_W-1:0] csr_write_data
);

   logic [lfa_pkg::FRM_W-1:0] frames_ff;
   logic adv;
   lfa_pkg::pipe_type div_chain [lfa_pkg::DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= lfa_pkg::FRAMES_RESET;
      end else if (csr_write_enable) begin
         frames_ff <= csr_write_data;
      end
   end

   assign req_ch.ready = adv;

   lfa_accum u_accum (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .in_valid(req_ch.valid && adv),
      .in_kind(req_ch.kind),
      .in_index(req_ch.pixel_index),
      .in_sample(req_ch.sample),
      .out_stage(div_chain[0])
   );

   for (genvar g = 0; g < lfa_pkg::DIV_STEPS; g++) begin : g_div
      lfa_div_step u_div_step (
         .clock(clock),
         .reset(reset),
         .adv(adv),
         .divisor(frames_ff),
         .in_stage(div_chain[g]),
         .out_stage(div_chain[g+1])
      );
   end

   lfa_out_buf u_out_buf (
      .clock(clock),
      .reset(reset),
      .in_stage(div_chain[lfa_pkg::DIV_STEPS]),
      .adv(adv),
      .rsp_ch(rsp_ch)
   );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for line_frame_averager_core, with a small scoreboard class
// that predicts each output pixel. Depends on lfa_pkg, lfa_req_if, lfa_rsp_if and the core.

module testbench;

   typedef struct packed {
      logic [lfa_pkg::SMP_W-1:0] pixel;
      logic [lfa_pkg::IDX_W-1:0] index;
      logic eol;
   } out_pixel_type;

   class line_average_board;
      logic [lfa_pkg::SUM_W-1:0] running_sum [lfa_pkg::LINE_PIXELS];
      logic [lfa_pkg::FRM_W-1:0] divisor;
      out_pixel_type expected_pixels[$];
      int mismatches;

      function new();
         divisor = lfa_pkg::FRAMES_RESET;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      function logic [lfa_pkg::SMP_W-1:0] mean_of(logic [lfa_pkg::SUM_W-1:0] total);
         logic [lfa_pkg::SUM_W-1:0] q;
         if (divisor == '0) begin
            return lfa_pkg::PIX_MAX;
         end
         q = total / divisor;
         return (q > lfa_pkg::PIX_MAX) ? lfa_pkg::PIX_MAX : q[lfa_pkg::SMP_W-1:0];
      endfunction

      function void note_pixel(logic [lfa_pkg::KIND_W-1:0] kind,
                               logic [lfa_pkg::IDX_W-1:0] idx,
                               logic [lfa_pkg::SMP_W-1:0] smp);
         logic [lfa_pkg::SUM_W:0] grown;
         out_pixel_type res;
         res.index = idx;
         res.eol = (int'(idx) == lfa_pkg::LINE_PIXELS - 1);
         res.pixel = smp;
         if (kind == lfa_pkg::KIND_SINGLE) begin
            expected_pixels.push_back(res);
            return;
         end
         if (int'(idx) >= lfa_pkg::LINE_PIXELS) begin
            return;
         end
         if (kind == lfa_pkg::KIND_FIRST) begin
            running_sum[idx] = lfa_pkg::SUM_W'(smp);
            return;
         end
         grown = {1'b0, running_sum[idx]} + (lfa_pkg::SUM_W + 1)'(smp);
         running_sum[idx] = grown[lfa_pkg::SUM_W] ? lfa_pkg::SUM_MAX
                                                   : grown[lfa_pkg::SUM_W-1:0];
         if (kind == lfa_pkg::KIND_LAST) begin
            res.pixel = mean_of(running_sum[idx]);
            expected_pixels.push_back(res);
         end
      endfunction

      function void check_pixel_out(logic [lfa_pkg::SMP_W-1:0] pix,
                                    logic [lfa_pkg::IDX_W-1:0] idx, logic eol);
         out_pixel_type want;
         if (expected_pixels.size() == 0) begin
            $error("unexpected item: pixel_out %0d index_out %0d end_of_line %0d",
                   pix, idx, eol);
            mismatches++;
            return;
         end
         want = expected_pixels.pop_front();
         if (pix !== want.pixel) begin
            $error("pixel_out: expected %0d, actual %0d", want.pixel, pix);
            mismatches++;
         end
         if (idx !== want.index) begin
            $error("index_out: expected %0d, actual %0d", want.index, idx);
            mismatches++;
         end
         if (eol !== want.eol) begin
            $error("end_of_line: expected %0d, actual %0d", want.eol, eol);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [lfa_pkg::FRM_W-1:0] csr_write_data;

   lfa_req_if req_ch();
   lfa_rsp_if rsp_ch();

   line_frame_averager_core dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   line_average_board board;
   bit idle_on;
   int items_sent;
   logic [lfa_pkg::FRM_W-1:0] frame_setting;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [lfa_pkg::IDX_W-1:0] pick_index();
      case ($urandom_range(0, 7))
         0: return '1;
         1: return '0;
         default: return lfa_pkg::IDX_W'($urandom_range(0, lfa_pkg::LINE_PIXELS - 1));
      endcase
   endfunction

   function automatic logic [lfa_pkg::SMP_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return lfa_pkg::PIX_MAX;
         1: return '0;
         default: return lfa_pkg::SMP_W'($urandom_range(0, 4095));
      endcase
   endfunction

   task automatic send_pixel(logic [lfa_pkg::KIND_W-1:0] role,
                             logic [lfa_pkg::IDX_W-1:0] idx,
                             logic [lfa_pkg::SMP_W-1:0] smp);
      int gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= role;
      req_ch.pixel_index <= idx;
      req_ch.sample <= smp;
      do @(posedge clock); while (!req_ch.ready);
      board.note_pixel(role, idx, smp);
      items_sent++;
   endtask

   // called right after an accepted item, so valid drops before any wait
   task automatic settle_pipeline();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      // first and middle items may still be in flight with nothing to wait for
      repeat (8) @(posedge clock);
   endtask

   task automatic write_frame_count(logic [lfa_pkg::FRM_W-1:0] value);
      settle_pipeline();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.divisor = value;
      frame_setting = value;
   endtask

   task automatic collect_pixels();
      int stall;
      forever begin
         stall = idle_on ? $urandom_range(0, 9) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         board.check_pixel_out(rsp_ch.pixel_out, rsp_ch.index_out, rsp_ch.end_of_line);
      end
   endtask

   // a single item or a stray add on a pixel that already had its first frame
   task automatic send_noise(logic [lfa_pkg::IDX_W-1:0] line_px[$]);
      logic [lfa_pkg::IDX_W-1:0] idx;
      idx = line_px[$urandom_range(0, line_px.size() - 1)];
      case ($urandom_range(0, 2))
         0: send_pixel(lfa_pkg::KIND_SINGLE, pick_index(), pick_sample());
         1: send_pixel(lfa_pkg::KIND_MIDDLE, idx, pick_sample());
         default: send_pixel(lfa_pkg::KIND_LAST, idx, pick_sample());
      endcase
   endtask

   // several pixels read out frame after frame, as the sensor delivers them
   task automatic run_readout();
      int npix;
      int nframes;
      logic [lfa_pkg::IDX_W-1:0] line_px[$];
      logic [lfa_pkg::KIND_W-1:0] role;
      npix = $urandom_range(1, 8);
      if (frame_setting >= 2 && frame_setting <= 6 && $urandom_range(0, 7) != 0) begin
         nframes = int'(frame_setting);
      end else begin
         nframes = $urandom_range(2, 6);
      end
      repeat (npix) line_px.push_back(pick_index());
      for (int f = 0; f < nframes; f++) begin
         role = (f == 0) ? lfa_pkg::KIND_FIRST :
                (f == nframes - 1) ? lfa_pkg::KIND_LAST : lfa_pkg::KIND_MIDDLE;
         foreach (line_px[p]) begin
            send_pixel(role, line_px[p], pick_sample());
            if (f > 0 && $urandom_range(0, 9) == 0) begin
               send_noise(line_px);
            end
         end
      end
   endtask

   initial begin
      logic [lfa_pkg::IDX_W-1:0] deep_px;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.kind <= lfa_pkg::KIND_SINGLE;
      req_ch.pixel_index <= '0;
      req_ch.sample <= '0;
      rsp_ch.ready <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data <= lfa_pkg::FRAMES_RESET;
      idle_on = 1'b1;
      items_sent = 0;
      frame_setting = lfa_pkg::FRAMES_RESET;
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      fork
         collect_pixels();
      join_none

      // pass-through at both ends of the line, then averages above range and zero
      send_pixel(lfa_pkg::KIND_SINGLE, '0, '0);
      send_pixel(lfa_pkg::KIND_SINGLE, '1, lfa_pkg::PIX_MAX);
      send_pixel(lfa_pkg::KIND_FIRST, '1, lfa_pkg::PIX_MAX);
      send_pixel(lfa_pkg::KIND_LAST, '1, lfa_pkg::PIX_MAX);
      send_pixel(lfa_pkg::KIND_FIRST, '0, '0);
      send_pixel(lfa_pkg::KIND_LAST, '0, '0);
      // zero frame count reads back all ones
      write_frame_count('0);
      send_pixel(lfa_pkg::KIND_FIRST, 12'd5, 12'd123);
      send_pixel(lfa_pkg::KIND_MIDDLE, 12'd5, 12'd4000);
      send_pixel(lfa_pkg::KIND_LAST, 12'd5, 12'd1);
      write_frame_count('1);
      send_pixel(lfa_pkg::KIND_FIRST, 12'd1, lfa_pkg::PIX_MAX);
      send_pixel(lfa_pkg::KIND_MIDDLE, 12'd1, lfa_pkg::PIX_MAX);
      send_pixel(lfa_pkg::KIND_LAST, 12'd1, lfa_pkg::PIX_MAX);
      write_frame_count(8'd3);
      send_pixel(lfa_pkg::KIND_FIRST, 12'd4094, lfa_pkg::PIX_MAX);
      send_pixel(lfa_pkg::KIND_MIDDLE, 12'd4094, lfa_pkg::PIX_MAX);
      send_pixel(lfa_pkg::KIND_LAST, 12'd4094, lfa_pkg::PIX_MAX);

      // enough full-scale frames on one pixel to saturate the sum
      write_frame_count('1);
      idle_on = 1'b0;
      deep_px = pick_index();
      send_pixel(lfa_pkg::KIND_FIRST, deep_px, lfa_pkg::PIX_MAX);
      repeat (256) send_pixel(lfa_pkg::KIND_MIDDLE, deep_px, lfa_pkg::PIX_MAX);
      send_pixel(lfa_pkg::KIND_LAST, deep_px, lfa_pkg::PIX_MAX);

      while (items_sent < 1250) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 9))
               0: write_frame_count('0);
               1: write_frame_count(8'd1);
               2: write_frame_count('1);
               3: write_frame_count(lfa_pkg::FRM_W'($urandom_range(1, 255)));
               default: write_frame_count(lfa_pkg::FRM_W'($urandom_range(2, 6)));
            endcase
         end else if ($urandom_range(0, 9) == 0) begin
            settle_pipeline();
         end
         idle_on = ($urandom_range(0, 3) != 0);
         run_readout();
      end

      settle_pipeline();
      repeat (12) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: line_frame_averager_core.f
rtl/lfa_pkg.sv
rtl/lfa_req_if.sv
rtl/lfa_rsp_if.sv
rtl/lfa_accum.sv
rtl/lfa_div_step.sv
rtl/lfa_out_buf.sv
rtl/line_frame_averager_core.sv
tb/testbench.sv
